// File: rtl/core/dflm_pkg.sv
// Shared types and codes for the descriptor free list manager.
package dflm_pkg;

  localparam logic [2:0] OP_INIT  = 3'd0;
  localparam logic [2:0] OP_ALLOC = 3'd1;
  localparam logic [2:0] OP_FREE  = 3'd2;
  localparam logic [2:0] OP_LINK  = 3'd3;
  localparam logic [2:0] OP_CHAIN = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;
  localparam logic [1:0] STAT_LONG  = 2'd3;

  localparam logic [8:0] QS_RESET = 9'd256;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] index;
    logic [7:0] next_index;
    logic       link_has_next;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] alloc_index;
    logic [8:0] free_count;
    logic [8:0] freed_count;
  } out_t;

endpackage

// File: rtl/core/dflm_desc_mem.sv
// Descriptor table: one write port, one registered read port.
module dflm_desc_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 9
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/dflm_seq.sv
// Sequencer and list state: head, free count, table sweeps and chain walk.
module dflm_seq
  import dflm_pkg::*;
#(
  parameter int MAX_DESCRIPTORS = 256,
  parameter int AW              = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [8:0]    n_eff,
  input  logic          in_valid,
  output logic          in_ready,
  input  in_t           in_data,
  output logic          resp_valid,
  input  logic          resp_ready,
  output out_t          resp_data,
  output logic          mem_wr_en,
  output logic [AW-1:0] mem_wr_addr,
  output logic [AW:0]   mem_wr_data,
  output logic          mem_rd_en,
  output logic [AW-1:0] mem_rd_addr,
  input  logic [AW:0]   mem_rd_data
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_SWEEP = 4'd3;
  localparam logic [3:0] S_ALLOC = 4'd4;
  localparam logic [3:0] S_CH_RD = 4'd5;
  localparam logic [3:0] S_CH_WB = 4'd6;
  localparam logic [3:0] S_RESP  = 4'd7;

  localparam logic [10:0] MAX_W      = 11'(MAX_DESCRIPTORS);
  localparam logic [AW:0] MAX_C      = (AW+1)'(MAX_DESCRIPTORS);
  localparam logic [8:0]  TOTAL_RST  = (11'(QS_RESET) > MAX_W) ?
                                       9'(MAX_DESCRIPTORS) : QS_RESET;

  logic [3:0]    state_r, state_nxt;
  in_t           req_r, req_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [8:0]    total_r, total_nxt;
  logic [8:0]    freed_r, freed_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [7:0]    alloc_r, alloc_nxt;

  logic [AW:0]   cnt_inc;
  logic [7:0]    clr_low;
  logic [AW-1:0] clr_link;
  logic [AW-1:0] init_link;
  logic          idx_oor;
  logic          nxt_oor;
  logic          total_ge_n;
  logic          rd_flag;
  logic [AW-1:0] rd_link;
  logic          succ_oor;

  assign cnt_inc    = cnt_r + 1'b1;
  // power-on layout: entry i links to (i+1) mod 256 when that is inside the table
  assign clr_low    = 8'(cnt_inc);
  assign clr_link   = (11'(clr_low) < MAX_W) ? AW'(clr_low) : '0;
  assign init_link  = (11'(cnt_inc) < 11'(n_eff)) ? AW'(cnt_inc) : '0;
  assign idx_oor    = ({1'b0, req_r.index} >= n_eff);
  assign nxt_oor    = ({1'b0, req_r.next_index} >= n_eff);
  assign total_ge_n = (total_r >= n_eff);
  assign rd_flag    = mem_rd_data[AW];
  assign rd_link    = mem_rd_data[AW-1:0];
  assign succ_oor   = (11'(rd_link) >= 11'(n_eff));

  assign in_ready   = (state_r == S_IDLE);
  assign resp_valid = (state_r == S_RESP);
  assign resp_data  = '{status: status_r, alloc_index: alloc_r,
                        free_count: total_r, freed_count: freed_r};

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    head_nxt    = head_r;
    total_nxt   = total_r;
    freed_nxt   = freed_r;
    cnt_nxt     = cnt_r;
    cur_nxt     = cur_r;
    status_nxt  = status_r;
    alloc_nxt   = alloc_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = cnt_r[AW-1:0];
    mem_wr_data = '0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = head_r;
    case (state_r)
      S_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = {1'b0, clr_link};
        cnt_nxt     = cnt_inc;
        if (cnt_inc == MAX_C) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        freed_nxt  = '0;
        alloc_nxt  = '0;
        status_nxt = STAT_OK;
        state_nxt  = S_RESP;
        case (req_r.opcode)
          OP_INIT: begin
            cnt_nxt   = '0;
            state_nxt = S_SWEEP;
          end
          OP_ALLOC: begin
            if (total_r == '0) begin
              status_nxt = STAT_FULL;
            end else begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = head_r;
              state_nxt   = S_ALLOC;
            end
          end
          OP_FREE: begin
            if (idx_oor) begin
              status_nxt = STAT_RANGE;
            end else if (total_ge_n) begin
              status_nxt = STAT_FULL;
            end else begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = AW'(req_r.index);
              mem_wr_data = {1'b0, head_r};
              head_nxt    = AW'(req_r.index);
              total_nxt   = total_r + 1'b1;
              freed_nxt   = 9'd1;
            end
          end
          OP_LINK: begin
            if (idx_oor || nxt_oor) begin
              status_nxt = STAT_RANGE;
            end else begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = AW'(req_r.index);
              mem_wr_data = {req_r.link_has_next, AW'(req_r.next_index)};
            end
          end
          OP_CHAIN: begin
            if (idx_oor) begin
              status_nxt = STAT_RANGE;
            end else begin
              cur_nxt   = AW'(req_r.index);
              state_nxt = S_CH_RD;
            end
          end
          default: begin
            status_nxt = STAT_OK;
          end
        endcase
      end
      S_SWEEP: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = {1'b0, init_link};
        cnt_nxt     = cnt_inc;
        if (11'(cnt_inc) == 11'(n_eff)) begin
          head_nxt  = '0;
          total_nxt = n_eff;
          state_nxt = S_RESP;
        end
      end
      S_ALLOC: begin
        head_nxt  = rd_link;
        total_nxt = total_r - 1'b1;
        alloc_nxt = 8'(head_r);
        state_nxt = S_RESP;
      end
      S_CH_RD: begin
        if (freed_r >= n_eff) begin
          status_nxt = STAT_LONG;
          state_nxt  = S_RESP;
        end else if (total_ge_n) begin
          status_nxt = STAT_FULL;
          state_nxt  = S_RESP;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = cur_r;
          state_nxt   = S_CH_WB;
        end
      end
      S_CH_WB: begin
        // push cur, then follow its successor while has-next is set and the successor is in range
        mem_wr_en   = 1'b1;
        mem_wr_addr = cur_r;
        mem_wr_data = {1'b0, head_r};
        head_nxt    = cur_r;
        total_nxt   = total_r + 1'b1;
        freed_nxt   = freed_r + 1'b1;
        if (!rd_flag) begin
          state_nxt = S_RESP;
        end else if (succ_oor) begin
          status_nxt = STAT_RANGE;
          state_nxt  = S_RESP;
        end else begin
          cur_nxt   = rd_link;
          state_nxt = S_CH_RD;
        end
      end
      S_RESP: begin
        if (resp_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
      head_r  <= '0;
      total_r <= TOTAL_RST;
      freed_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      head_r  <= head_nxt;
      total_r <= total_nxt;
      freed_r <= freed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    cur_r    <= cur_nxt;
    status_r <= status_nxt;
    alloc_r  <= alloc_nxt;
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sequencer ready right after taking a transaction");

  a_walk_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CH_WB) |=> (freed_r == $past(freed_r) + 9'd1) &&
                             (total_r == $past(total_r) + 9'd1))
    else $error("chain walk step did not push one descriptor");

  a_alloc_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALLOC) |=> (total_r == $past(total_r) - 9'd1) &&
                             (head_r == $past(rd_link)))
    else $error("alloc did not pop the head");

  a_no_resp_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (!resp_valid && !in_ready))
    else $error("activity during table clear");

endmodule

// File: rtl/core/descriptor_free_list_manager.sv
// Descriptor free list manager: one transaction in, one result out. Free, link, unused
// opcodes and anything rejected at dispatch (including alloc on an empty list) finish in
// the dispatch state, a successful alloc reads the head entry and then pops it, init
// sweeps the table up to the effective queue size, and free chain reads and pushes each
// descriptor in turn, stopping early on a full list or an over-long chain; each table
// access goes through the descriptor table, with one write and one registered read port.
// After reset the table is laid out by a clearing pass over all MAX_DESCRIPTORS entries
// during which no transaction is accepted (queue_size writes are taken throughout). The
// result register lets the next transaction start while a result waits to be taken.
module descriptor_free_list_manager
  import dflm_pkg::*;
#(
  parameter int MAX_DESCRIPTORS = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic [8:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_DESCRIPTORS);
  localparam logic [10:0] MAX_W = 11'(MAX_DESCRIPTORS);

  logic [8:0]    queue_size_r;
  logic [8:0]    n_eff;
  logic          seq_ready;
  logic          resp_valid;
  logic          resp_ready;
  out_t          resp_data;
  logic          out_valid_r;
  out_t          out_data_r;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [AW:0]   mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic [AW:0]   mem_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_size_r <= QS_RESET;
    end else if (cfg_we) begin
      queue_size_r <= cfg_wdata;
    end
  end

  // zero acts as one, anything past the table as the table size
  always_comb begin
    if (queue_size_r == '0) begin
      n_eff = 9'd1;
    end else if (11'(queue_size_r) > MAX_W) begin
      n_eff = 9'(MAX_DESCRIPTORS);
    end else begin
      n_eff = queue_size_r;
    end
  end

  dflm_seq #(
    .MAX_DESCRIPTORS(MAX_DESCRIPTORS),
    .AW(AW)
  ) u_seq (
    .clk(clk),
    .rst_n(rst_n),
    .n_eff(n_eff),
    .in_valid(in_valid),
    .in_ready(seq_ready),
    .in_data(in_data),
    .resp_valid(resp_valid),
    .resp_ready(resp_ready),
    .resp_data(resp_data),
    .mem_wr_en(mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data),
    .mem_rd_en(mem_rd_en),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data)
  );

  dflm_desc_mem #(
    .DEPTH(MAX_DESCRIPTORS),
    .AW(AW),
    .DW(AW + 1)
  ) u_mem (
    .clk(clk),
    .wr_en(mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en(mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  assign in_stall   = !seq_ready;
  assign resp_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resp_valid && resp_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_valid && resp_ready) begin
      out_data_r <= resp_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
